[rtl/core/sam_pkg.sv]
// ----------------------------------------------------------------------------
// sam_pkg
// Shared types and codes for the suffix automaton substring matcher.
// ----------------------------------------------------------------------------
package sam_pkg;

    typedef enum logic [1:0] {
        KIND_CLEAR    = 2'd0,
        KIND_PATTERN  = 2'd1,
        KIND_TEXT     = 2'd2,
        KIND_NEW_TEXT = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ZERO,
        ST_WALK,
        ST_WALK_LINK,
        ST_LEN_P,
        ST_LEN_D,
        ST_COPY,
        ST_REDIRECT,
        ST_REDIRECT_LINK,
        ST_REDIRECT_CHK,
        ST_FIX_D,
        ST_FIX_CUR,
        ST_M_CHK,
        ST_M_LINK,
        ST_M_LEN,
        ST_DONE
    } state_t;

    localparam int BEST_W  = 7;
    localparam int CUR_W   = 7;
    localparam int COUNT_W = 8;
    localparam int OUT_W   = BEST_W + CUR_W + COUNT_W + 2;
    localparam int THR_W   = 8;

endpackage

[rtl/core/suffix_automaton_lcs_matcher.sv]
// ----------------------------------------------------------------------------
// suffix_automaton_lcs_matcher
// Builds a suffix automaton from pattern symbols and tracks the longest
// common substring of the current text against it.
// ----------------------------------------------------------------------------
//  channel  | signals                       | contents
//  ---------+-------------------------------+------------------------------
//  s_       | s_tvalid s_tready s_tdata/user| command kind and symbol
//  m_       | m_tvalid m_tready m_tdata     | lengths, state count, flags
//  cfg_     | cfg_wr_en cfg_wr_data         | min_match_threshold
//
//  A pattern symbol first sweeps the new state's transition row to zero and
//  then walks the suffix links; when the walk meets an existing transition
//  it reads both lengths, and when a state is cloned it copies the row of
//  transitions and redirects transitions until the redirect reaches the root
//  or stops on another target. A text symbol falls back along suffix links.
//  Reset is synchronous; one item is in work at a time and a held result
//  stalls only the last cycle of the next item.
// ----------------------------------------------------------------------------
module suffix_automaton_lcs_matcher
    import sam_pkg::*;
#(
    parameter int ALPHABET_SIZE = 32,
    parameter int MAX_PATTERN   = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,      // [7:0] symbol
    input  logic [1:0]        s_tuser,      // [1:0] kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,      // [6:0] best_length, [13:7] current_length,
                                            // [21:14] state_count, [22] pattern_full,
                                            // [23] matching_enabled
    input  logic              cfg_wr_en,
    input  logic [THR_W-1:0]  cfg_wr_data
);

    localparam int MAX_STATES = 2 * MAX_PATTERN;
    localparam int SW   = $clog2(MAX_STATES);
    localparam int CW   = $clog2(MAX_STATES + 1);
    localparam int LW   = $clog2(MAX_PATTERN + 1);
    localparam int LTW  = $clog2(ALPHABET_SIZE);
    localparam int KW   = $clog2(ALPHABET_SIZE + 1);
    localparam int TAW  = $clog2(MAX_STATES * ALPHABET_SIZE);
    localparam int NW   = SW + LW;
    localparam int CMPW = (CW > THR_W) ? CW : THR_W;

    state_t state_reg, state_next;

    logic [SW-1:0]  tr_mem [MAX_STATES * ALPHABET_SIZE];
    logic [NW-1:0]  nd_mem [MAX_STATES];

    logic           tr_rd_en, tr_wr_en, nd_rd_en, nd_wr_en;
    logic [SW-1:0]  tr_rd_st, tr_wr_st, tr_wr_data, nd_rd_addr, nd_wr_addr;
    logic [LTW-1:0] tr_rd_let, tr_wr_let;
    logic [NW-1:0]  nd_wr_data;
    logic [TAW-1:0] tr_rd_addr, tr_wr_addr;

    logic [SW-1:0]  tr_q_reg;
    logic           tr_root_reg;
    logic [LTW-1:0] tr_let_reg;
    logic [NW-1:0]  nd_q_reg;
    logic           nd_zero_reg;
    logic [SW-1:0]  tr_q, link_q;
    logic [LW-1:0]  len_q;

    logic [CW-1:0]  states_reg, states_next;
    logic [SW-1:0]  last_reg, last_next, ms_reg, ms_next, p_reg, p_next;
    logic [SW-1:0]  cur_reg, cur_next, cl_reg, cl_next, d_reg, d_next;
    logic [SW-1:0]  linkd_reg, linkd_next;
    logic [LW-1:0]  raw_reg, raw_next, ml_reg, ml_next, best_reg, best_next;
    logic [LW-1:0]  cur_len_reg, cur_len_next, lenp_reg, lenp_next;
    logic [LW-1:0]  lend_reg, lend_next, ml_new;
    logic           drop_reg, drop_next;
    logic [THR_W-1:0] thr_reg;
    kind_t          kind_reg;
    logic [LTW-1:0] let_reg;
    logic           sym_ok_reg;
    logic [KW-1:0]  k_reg, k_next;
    logic [KW-1:0]  k_prev;
    logic [ALPHABET_SIZE-1:0] root_vld_reg, root_vld_next;
    logic           out_vld_reg, out_vld_next;
    logic [OUT_W-1:0] out_reg, out_next;
    logic           enabled, accept, sym_ok;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;
    assign sym_ok   = (s_tdata >= 8'd1) && (s_tdata <= 8'(ALPHABET_SIZE));
    assign k_prev   = k_reg - KW'(1);

    assign enabled = (CMPW'(raw_reg) >= CMPW'(thr_reg)) &&
                     (CMPW'(states_reg) > CMPW'(thr_reg));

    assign tr_q   = (tr_root_reg && !root_vld_reg[tr_let_reg]) ? '0 : tr_q_reg;
    assign link_q = nd_zero_reg ? '0 : nd_q_reg[NW-1:LW];
    assign len_q  = nd_zero_reg ? '0 : nd_q_reg[LW-1:0];

    assign tr_rd_addr = TAW'(tr_rd_st) * TAW'(ALPHABET_SIZE) + TAW'(tr_rd_let);
    assign tr_wr_addr = TAW'(tr_wr_st) * TAW'(ALPHABET_SIZE) + TAW'(tr_wr_let);

    always_ff @(posedge aclk) begin
        if (tr_wr_en) begin
            tr_mem[tr_wr_addr] <= tr_wr_data;
        end
        if (tr_rd_en) begin
            tr_q_reg    <= tr_mem[tr_rd_addr];
            tr_root_reg <= (tr_rd_st == '0);
            tr_let_reg  <= tr_rd_let;
        end
        if (nd_wr_en) begin
            nd_mem[nd_wr_addr] <= nd_wr_data;
        end
        if (nd_rd_en) begin
            nd_q_reg    <= nd_mem[nd_rd_addr];
            nd_zero_reg <= (nd_rd_addr == '0);
        end
    end

    always_comb begin
        state_next    = state_reg;
        states_next   = states_reg;
        last_next     = last_reg;
        ms_next       = ms_reg;
        p_next        = p_reg;
        cur_next      = cur_reg;
        cl_next       = cl_reg;
        d_next        = d_reg;
        linkd_next    = linkd_reg;
        raw_next      = raw_reg;
        ml_next       = ml_reg;
        best_next     = best_reg;
        cur_len_next  = cur_len_reg;
        lenp_next     = lenp_reg;
        lend_next     = lend_reg;
        drop_next     = drop_reg;
        k_next        = k_reg;
        root_vld_next = root_vld_reg;
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        ml_new        = ml_reg;
        tr_rd_en   = 1'b0;
        tr_rd_st   = '0;
        tr_rd_let  = let_reg;
        tr_wr_en   = 1'b0;
        tr_wr_st   = '0;
        tr_wr_let  = let_reg;
        tr_wr_data = '0;
        nd_rd_en   = 1'b0;
        nd_rd_addr = '0;
        nd_wr_en   = 1'b0;
        nd_wr_addr = '0;
        nd_wr_data = '0;

        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                unique case (kind_reg)
                    KIND_CLEAR: begin
                        states_next   = CW'(1);
                        last_next     = '0;
                        raw_next      = '0;
                        ms_next       = '0;
                        ml_next       = '0;
                        best_next     = '0;
                        drop_next     = 1'b0;
                        root_vld_next = '0;
                    end
                    KIND_PATTERN: begin
                        if (raw_reg >= LW'(MAX_PATTERN) ||
                            states_reg > CW'(MAX_STATES - 2)) begin
                            drop_next = 1'b1;
                        end else begin
                            raw_next = raw_reg + LW'(1);
                            if (sym_ok_reg) begin
                                cur_next    = states_reg[SW-1:0];
                                states_next = states_reg + CW'(1);
                                nd_rd_en    = 1'b1;
                                nd_rd_addr  = last_reg;
                                k_next      = '0;
                                state_next  = ST_ZERO;
                            end
                        end
                    end
                    KIND_TEXT: begin
                        if (sym_ok_reg && enabled) begin
                            tr_rd_en   = 1'b1;
                            tr_rd_st   = ms_reg;
                            state_next = ST_M_CHK;
                        end
                    end
                    KIND_NEW_TEXT: begin
                        ms_next   = '0;
                        ml_next   = '0;
                        best_next = '0;
                    end
                    default: ;
                endcase
            end
            ST_ZERO: begin
                tr_wr_en   = 1'b1;
                tr_wr_st   = cur_reg;
                tr_wr_let  = k_reg[LTW-1:0];
                tr_wr_data = '0;
                if (k_reg == '0) begin
                    cur_len_next = len_q + LW'(1);
                end
                if (k_reg == KW'(ALPHABET_SIZE - 1)) begin
                    nd_wr_en   = 1'b1;
                    nd_wr_addr = cur_reg;
                    nd_wr_data = {SW'(0), cur_len_reg};
                    p_next     = last_reg;
                    tr_rd_en   = 1'b1;
                    tr_rd_st   = last_reg;
                    state_next = ST_WALK;
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_WALK: begin
                nd_rd_en   = 1'b1;
                nd_rd_addr = p_reg;
                if (tr_q == '0) begin
                    tr_wr_en   = 1'b1;
                    tr_wr_st   = p_reg;
                    tr_wr_data = cur_reg;
                    state_next = ST_WALK_LINK;
                end else begin
                    d_next     = tr_q;
                    state_next = ST_LEN_P;
                end
            end
            ST_WALK_LINK: begin
                if (link_q == p_reg) begin
                    last_next  = cur_reg;
                    state_next = ST_DONE;
                end else begin
                    p_next     = link_q;
                    tr_rd_en   = 1'b1;
                    tr_rd_st   = link_q;
                    state_next = ST_WALK;
                end
            end
            ST_LEN_P: begin
                lenp_next  = len_q;
                nd_rd_en   = 1'b1;
                nd_rd_addr = d_reg;
                state_next = ST_LEN_D;
            end
            ST_LEN_D: begin
                if (lenp_reg + LW'(1) == len_q) begin
                    nd_wr_en   = 1'b1;
                    nd_wr_addr = cur_reg;
                    nd_wr_data = {d_reg, cur_len_reg};
                    last_next  = cur_reg;
                    state_next = ST_DONE;
                end else begin
                    lend_next   = len_q;
                    linkd_next  = link_q;
                    cl_next     = states_reg[SW-1:0];
                    states_next = states_reg + CW'(1);
                    k_next      = '0;
                    state_next  = ST_COPY;
                end
            end
            ST_COPY: begin
                if (k_reg != KW'(ALPHABET_SIZE)) begin
                    tr_rd_en  = 1'b1;
                    tr_rd_st  = d_reg;
                    tr_rd_let = k_reg[LTW-1:0];
                end
                if (k_reg != '0) begin
                    tr_wr_en   = 1'b1;
                    tr_wr_st   = cl_reg;
                    tr_wr_let  = k_prev[LTW-1:0];
                    tr_wr_data = tr_q;
                end
                if (k_reg == KW'(ALPHABET_SIZE)) begin
                    nd_wr_en   = 1'b1;
                    nd_wr_addr = cl_reg;
                    nd_wr_data = {linkd_reg, lenp_reg + LW'(1)};
                    state_next = ST_REDIRECT;
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_REDIRECT: begin
                tr_wr_en   = 1'b1;
                tr_wr_st   = p_reg;
                tr_wr_data = cl_reg;
                nd_rd_en   = 1'b1;
                nd_rd_addr = p_reg;
                state_next = ST_REDIRECT_LINK;
            end
            ST_REDIRECT_LINK: begin
                if (link_q == p_reg) begin
                    state_next = ST_FIX_D;
                end else begin
                    p_next     = link_q;
                    tr_rd_en   = 1'b1;
                    tr_rd_st   = link_q;
                    state_next = ST_REDIRECT_CHK;
                end
            end
            ST_REDIRECT_CHK: begin
                if (tr_q == d_reg) begin
                    tr_wr_en   = 1'b1;
                    tr_wr_st   = p_reg;
                    tr_wr_data = cl_reg;
                    nd_rd_en   = 1'b1;
                    nd_rd_addr = p_reg;
                    state_next = ST_REDIRECT_LINK;
                end else begin
                    state_next = ST_FIX_D;
                end
            end
            ST_FIX_D: begin
                nd_wr_en   = 1'b1;
                nd_wr_addr = d_reg;
                nd_wr_data = {cl_reg, lend_reg};
                state_next = ST_FIX_CUR;
            end
            ST_FIX_CUR: begin
                nd_wr_en   = 1'b1;
                nd_wr_addr = cur_reg;
                nd_wr_data = {cl_reg, cur_len_reg};
                last_next  = cur_reg;
                state_next = ST_DONE;
            end
            ST_M_CHK: begin
                if (ms_reg != '0 && tr_q == '0) begin
                    nd_rd_en   = 1'b1;
                    nd_rd_addr = ms_reg;
                    state_next = ST_M_LINK;
                end else begin
                    if (tr_q != '0) begin
                        ms_next = tr_q;
                        ml_new  = ml_reg + LW'(1);
                    end
                    ml_next = ml_new;
                    if (ml_new > best_reg) begin
                        best_next = ml_new;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_M_LINK: begin
                ms_next    = link_q;
                nd_rd_en   = 1'b1;
                nd_rd_addr = link_q;
                state_next = ST_M_LEN;
            end
            ST_M_LEN: begin
                ml_next    = len_q;
                tr_rd_en   = 1'b1;
                tr_rd_st   = ms_reg;
                state_next = ST_M_CHK;
            end
            ST_DONE: begin
                if (!out_vld_reg || m_tready) begin
                    out_vld_next = 1'b1;
                    out_next     = {enabled, drop_reg, COUNT_W'(states_reg),
                                    CUR_W'(ml_reg), BEST_W'(best_reg)};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (tr_wr_en && tr_wr_st == '0) begin
            root_vld_next[tr_wr_let] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            states_reg   <= CW'(1);
            last_reg     <= '0;
            raw_reg      <= '0;
            ms_reg       <= '0;
            ml_reg       <= '0;
            best_reg     <= '0;
            drop_reg     <= 1'b0;
            thr_reg      <= THR_W'(1);
            root_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            states_reg   <= states_next;
            last_reg     <= last_next;
            raw_reg      <= raw_next;
            ms_reg       <= ms_next;
            ml_reg       <= ml_next;
            best_reg     <= best_next;
            drop_reg     <= drop_next;
            root_vld_reg <= root_vld_next;
            out_vld_reg  <= out_vld_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        cur_reg     <= cur_next;
        cl_reg      <= cl_next;
        d_reg       <= d_next;
        linkd_reg   <= linkd_next;
        cur_len_reg <= cur_len_next;
        lenp_reg    <= lenp_next;
        lend_reg    <= lend_next;
        k_reg       <= k_next;
        out_reg     <= out_next;
        if (accept) begin
            kind_reg   <= kind_t'(s_tuser);
            let_reg    <= LTW'(s_tdata - 8'd1);
            sym_ok_reg <= sym_ok;
        end
    end

endmodule

[rtl/core/sam_checker.sv]
// ----------------------------------------------------------------------------
// sam_checker
// Port-level checks for the suffix automaton substring matcher.
// ----------------------------------------------------------------------------
module sam_checker
    import sam_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result or busy after reset");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while working");

    a_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[BEST_W+CUR_W+COUNT_W-1:BEST_W+CUR_W] != '0)
        else $error("state count lost the root");

    a_best: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[BEST_W-1:0] >= m_tdata[BEST_W+CUR_W-1:BEST_W])
        else $error("best length below current length");

endmodule

bind suffix_automaton_lcs_matcher sam_checker u_sam_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[verif/suffix_automaton_lcs_matcher_tb.sv]
// ----------------------------------------------------------------------------
// suffix_automaton_lcs_matcher_tb
// Drives clear, pattern, text and new-text commands into the matcher, with
// random gaps and receiver stalls, and checks every result against an
// in-bench automaton builder and text scanner.
// ----------------------------------------------------------------------------
module suffix_automaton_lcs_matcher_tb;
    import sam_pkg::*;

    localparam int ALPHA   = 32;
    localparam int MAXPAT  = 64;
    localparam int NSTATES = 2 * MAXPAT;
    localparam int LIMIT   = 2000000;

    typedef struct packed {
        logic       enabled;
        logic       full;
        logic [7:0] count;
        logic [6:0] cur;
        logic [6:0] best;
    } lcs_result_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] sym;
        logic       fixed;
        logic [6:0] best;
        logic [6:0] cur;
        logic [7:0] count;
        logic       full;
        logic       enabled;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic [1:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_wr_en = 1'b0;
    logic [THR_W-1:0]  cfg_wr_data = '0;

    suffix_automaton_lcs_matcher uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // automaton copy
    logic [6:0] trans [NSTATES][ALPHA];
    logic [6:0] link [NSTATES];
    logic [6:0] slen [NSTATES];
    int unsigned n_states, last_st, raw_len, m_state, m_len, best_len, thresh;
    bit dropped;

    lcs_result_t expected_q[$];
    int errors = 0;
    int cycles = 0;
    bit quiet_rx = 1'b0;
    bit hold_rx = 1'b0;
    bit quiet_tx = 1'b0;

    function automatic void sam_clear();
        for (int s = 0; s < NSTATES; s++) begin
            link[s] = '0;
            slen[s] = '0;
            for (int c = 0; c < ALPHA; c++) trans[s][c] = '0;
        end
        n_states = 1; last_st = 0; raw_len = 0;
        m_state = 0; m_len = 0; best_len = 0; dropped = 0;
    endfunction

    function automatic bit sam_enabled();
        return raw_len >= thresh && n_states > thresh;
    endfunction

    function automatic void sam_extend(int unsigned c);
        int unsigned cur, p, q, d, cl;
        bit stop;
        cur = n_states++;
        p = last_st;
        stop = 0;
        for (int k = 0; k < ALPHA; k++) trans[cur][k] = '0;
        slen[cur] = 7'(slen[last_st] + 1);
        link[cur] = '0;
        while (!stop && trans[p][c] == 0) begin
            trans[p][c] = 7'(cur);
            q = p; p = link[p]; stop = (p == q);
        end
        if (!stop) begin
            d = trans[p][c];
            if (slen[p] + 1 == slen[d]) begin
                link[cur] = 7'(d);
            end else begin
                cl = n_states++;
                for (int k = 0; k < ALPHA; k++) trans[cl][k] = trans[d][k];
                link[cl] = link[d];
                slen[cl] = 7'(slen[p] + 1);
                while (!stop && trans[p][c] == d) begin
                    trans[p][c] = 7'(cl);
                    q = p; p = link[p]; stop = (p == q);
                end
                link[d] = 7'(cl);
                link[cur] = 7'(cl);
            end
        end
        last_st = cur;
    endfunction

    function automatic lcs_result_t sam_apply(kind_t kind, logic [7:0] sym);
        lcs_result_t r;
        bit ok;
        int unsigned c;
        ok = sym >= 1 && sym <= ALPHA;
        c = sym - 1;
        case (kind)
            KIND_CLEAR: sam_clear();
            KIND_PATTERN: begin
                if (raw_len >= MAXPAT || n_states + 2 > NSTATES) begin
                    dropped = 1;
                end else begin
                    raw_len++;
                    if (ok) sam_extend(c);
                end
            end
            KIND_TEXT: begin
                if (ok && sam_enabled()) begin
                    while (m_state != 0 && trans[m_state][c] == 0) begin
                        m_state = link[m_state];
                        m_len = slen[m_state];
                    end
                    if (trans[m_state][c] != 0) begin
                        m_state = trans[m_state][c];
                        m_len++;
                    end
                    if (m_len > best_len) best_len = m_len;
                end
            end
            default: begin
                m_state = 0; m_len = 0; best_len = 0;
            end
        endcase
        r.best = 7'(best_len);
        r.cur = 7'(m_len);
        r.count = 8'(n_states);
        r.full = dropped;
        r.enabled = sam_enabled();
        return r;
    endfunction

    task automatic send(kind_t kind, logic [7:0] sym);
        while (!quiet_tx && $urandom_range(99) < 14) @(posedge aclk);
        expected_q.push_back(sam_apply(kind, sym));
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= sym;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_threshold(logic [7:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        thresh = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // pattern then text with random content, mostly symbols 1 to span, with some new-text and pattern items in the text
    task automatic random_phase(int n_pat, int n_txt, int span);
        send(KIND_CLEAR, 8'($urandom));
        for (int i = 0; i < n_pat; i++) begin
            if ($urandom_range(19) == 0) send(KIND_PATTERN, 8'($urandom_range(255)));
            else send(KIND_PATTERN, 8'($urandom_range(span, 1)));
        end
        send(KIND_NEW_TEXT, 8'($urandom));
        for (int i = 0; i < n_txt; i++) begin
            case ($urandom_range(29))
                0: send(KIND_NEW_TEXT, 8'($urandom));
                1: send(KIND_PATTERN, 8'($urandom_range(span, 1)));
                2: send(KIND_TEXT, 8'($urandom_range(255)));
                default: send(KIND_TEXT, 8'($urandom_range(span, 1)));
            endcase
        end
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_tdata);
                errors++;
            end else begin
                lcs_result_t e, a;
                e = expected_q.pop_front();
                a = m_tdata;
                if (a !== e) begin
                    $display("%0t mismatch expected %h actual %h", $time, e, a);
                    errors++;
                end
            end
        end
        m_tready <= !hold_rx && (quiet_rx || $urandom_range(99) >= 14);
    end

    stim_row_t dir_rows[$];

    function automatic void row(kind_t k, logic [7:0] s, logic f = 0, int b = 0,
                                int c = 0, int n = 0, logic fl = 0, logic en = 0);
        stim_row_t r;
        r.kind = k; r.sym = s; r.fixed = f; r.best = 7'(b); r.cur = 7'(c);
        r.count = 8'(n); r.full = fl; r.enabled = en;
        dir_rows.push_back(r);
    endfunction

    initial begin
        lcs_result_t got;
        thresh = 1;
        sam_clear();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        row(KIND_TEXT, 8'd1, 1, 0, 0, 1, 0, 0);
        row(KIND_NEW_TEXT, 8'hFF, 1, 0, 0, 1, 0, 0);
        row(KIND_PATTERN, 8'd0, 1, 0, 0, 1, 0, 0);
        row(KIND_PATTERN, 8'd33, 1, 0, 0, 1, 0, 0);
        row(KIND_PATTERN, 8'd1);
        row(KIND_PATTERN, 8'd2);
        row(KIND_PATTERN, 8'd1);
        row(KIND_PATTERN, 8'd1);
        row(KIND_PATTERN, 8'd32);
        row(KIND_PATTERN, 8'd2);
        row(KIND_TEXT, 8'd1);
        row(KIND_TEXT, 8'd2);
        row(KIND_TEXT, 8'd1);
        row(KIND_TEXT, 8'hFF);
        row(KIND_TEXT, 8'd0);
        row(KIND_TEXT, 8'd32);
        row(KIND_TEXT, 8'd5);
        row(KIND_NEW_TEXT, 8'd0);
        row(KIND_TEXT, 8'd2);
        row(KIND_CLEAR, 8'hFF, 1, 0, 0, 1, 0, 0);
        foreach (dir_rows[i]) begin
            send(dir_rows[i].kind, dir_rows[i].sym);
            if (dir_rows[i].fixed) begin
                got = expected_q[$];
                if (got.best != dir_rows[i].best || got.cur != dir_rows[i].cur ||
                    got.count != dir_rows[i].count || got.full != dir_rows[i].full ||
                    got.enabled != dir_rows[i].enabled) begin
                    $display("%0t table row %0d expected %h actual %h", $time, i,
                             {dir_rows[i].enabled, dir_rows[i].full, dir_rows[i].count,
                              dir_rows[i].cur, dir_rows[i].best}, got);
                    errors++;
                end
            end
        end

        // fill to capacity, then drop
        for (int i = 0; i < MAXPAT + 3; i++) send(KIND_PATTERN, 8'($urandom_range(2, 1)));
        send(KIND_TEXT, 8'd1);

        set_threshold(8'd128);
        random_phase(64, 20, 3);
        set_threshold(8'd4);
        random_phase(12, 60, 2);

        // long receiver hold-off while items keep coming
        fork
            begin
                hold_rx = 1'b1;
                repeat (400) @(posedge aclk);
                hold_rx = 1'b0;
            end
            random_phase(6, 20, 2);
        join

        set_threshold(8'd1);
        quiet_rx = 1'b1; quiet_tx = 1'b1;
        random_phase(20, 60, 4);
        quiet_rx = 1'b0; quiet_tx = 1'b0;
        set_threshold(8'd255);
        random_phase(8, 10, 3);
        set_threshold(8'd2);
        random_phase(30, 80, 32);
        set_threshold(8'd1);
        random_phase(10, 50, 2);

        drain();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
